// ----- hdl/btrb_pkg.sv -----
// Shared constants, request codes, command/status structs and helpers for the bin tree map.
package btrb_pkg;

  localparam int unsigned MaxLayers = 10;
  localparam int unsigned BinW      = MaxLayers + 1;
  localparam int unsigned MapDepth  = 2 ** BinW;
  localparam int unsigned CurW      = BinW + 2;
  localparam int unsigned LayerW    = 4;
  localparam int unsigned ReqW      = 3;

  localparam logic [ReqW-1:0] REQ_SET         = 3'd0;
  localparam logic [ReqW-1:0] REQ_RESET       = 3'd1;
  localparam logic [ReqW-1:0] REQ_QUERY       = 3'd2;
  localparam logic [ReqW-1:0] REQ_FIND_EMPTY  = 3'd3;
  localparam logic [ReqW-1:0] REQ_FIND_FILLED = 3'd4;
  localparam logic [ReqW-1:0] REQ_COVER       = 3'd5;

  typedef enum logic [2:0] {
    RD_CUR,
    RD_PARENT,
    RD_SIB,
    RD_LEFT,
    RD_ROOT,
    RD_ADDR
  } rd_sel_e;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_UP,
    CUR_RIGHT,
    CUR_DESC,
    CUR_RESTORE
  } cur_op_e;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_any;
    logic    wr_all;
    logic    wr_val;
    logic    wr_iv;
    logic    wr_sweep;
    cur_op_e cur_op;
    logic    desc_left;
    logic    iv_init;
    logic    iv_and;
    logic    set_found;
    logic    sw_init;
    logic    sw_inc;
    logic    out_load;
    logic    out_zero;
  } cmd_t;

  typedef struct packed {
    logic [ReqW-1:0] req;
    logic            invalid;
    logic            is_root;
    logic            rd_any;
    logic            rd_all;
    logic            iv;
    logic            cur_is_root;
    logic            layer_lt_rl;
    logic            layer_zero;
    logic            nx_over_top;
    logic            sw_last;
  } status_t;

  // layer of a bin = count of trailing ones
  function automatic logic [LayerW-1:0] layer_of(input logic [BinW-1:0] b);
    logic [LayerW-1:0] l;
    logic              run;
    l   = '0;
    run = 1'b1;
    for (int k = 0; k < BinW; k++) begin
      if (run && b[k]) begin
        l = l + 1'b1;
      end else begin
        run = 1'b0;
      end
    end
    return l;
  endfunction

endpackage

// ----- hdl/btrb_dpath.sv -----
// Datapath: bitmaps, tree walk registers, sweep counter, config and result registers.
module btrb_dpath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [btrb_pkg::LayerW-1:0]       cfg_data_i,
  input  logic [btrb_pkg::ReqW-1:0]         req_type_i,
  input  logic [btrb_pkg::BinW-1:0]         bin_number_i,
  input  logic                              whole_map_i,
  input  btrb_pkg::cmd_t                    cmd_i,
  output btrb_pkg::status_t                 status_o,
  output logic                              bin_empty_o,
  output logic                              bin_filled_o,
  output logic                              found_o,
  output logic [btrb_pkg::BinW-1:0]         result_bin_o,
  output logic                              out_of_range_o
);

  localparam int unsigned BinW   = btrb_pkg::BinW;
  localparam int unsigned CurW   = btrb_pkg::CurW;
  localparam int unsigned LayerW = btrb_pkg::LayerW;
  localparam int unsigned ReqW   = btrb_pkg::ReqW;

  logic [LayerW-1:0] root_layer_q;
  logic [LayerW-1:0] rl;
  logic [BinW:0]     pow_rl;
  logic [BinW:0]     top_w;
  logic [BinW-1:0]   root;
  logic [BinW-1:0]   top;

  logic [ReqW-1:0]   req_q;
  logic [BinW-1:0]   addr_q;
  logic [LayerW-1:0] addr_layer_q;
  logic              oor_q;
  logic              invalid_q;
  logic [CurW-1:0]   cur_q;
  logic [LayerW-1:0] layer_q;
  logic              iv_q;
  logic              found_q;
  logic [BinW-1:0]   res_q;
  logic              rd_any_q;
  logic              rd_all_q;
  logic [BinW-1:0]   sw_q;
  logic [BinW-1:0]   sw_end_q;

  logic [BinW-1:0]   addr_in;
  logic              oor_in;
  logic [CurW-1:0]   bit_l;
  logic [CurW-1:0]   bit_l1;
  logic [CurW-1:0]   half;
  logic [CurW-1:0]   parent_cur;
  logic [CurW-1:0]   sib_cur;
  logic [CurW-1:0]   left_cur;
  logic [CurW-1:0]   right_cur;
  logic [CurW-1:0]   nx;
  logic [CurW-1:0]   nx_par;
  logic              step_up;
  logic [BinW-1:0]   rd_addr;
  logic [BinW-1:0]   wr_addr;
  logic              wr_bit;
  logic [BinW:0]     span_w;
  logic [BinW-1:0]   span;

  logic any_mem [btrb_pkg::MapDepth];
  logic all_mem [btrb_pkg::MapDepth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_layer_q <= LayerW'(btrb_pkg::MaxLayers);
    end else if (cfg_valid_i) begin
      root_layer_q <= cfg_data_i;
    end
  end

  always_comb begin
    rl     = (root_layer_q > LayerW'(btrb_pkg::MaxLayers)) ?
             LayerW'(btrb_pkg::MaxLayers) : root_layer_q;
    pow_rl = (BinW+1)'(1) << rl;
    top_w  = (pow_rl << 1) - (BinW+1)'(2);
    root   = BinW'(pow_rl - (BinW+1)'(1));
    top    = top_w[BinW-1:0];
  end

  // find-filled always works from the root
  assign addr_in = (whole_map_i || req_type_i == btrb_pkg::REQ_FIND_FILLED) ? root : bin_number_i;
  assign oor_in  = (req_type_i <= btrb_pkg::REQ_COVER) && (addr_in > top);

  // tree neighbors of the current bin, from its layer
  always_comb begin
    bit_l      = CurW'(1) << layer_q;
    bit_l1     = bit_l << 1;
    half       = bit_l >> 1;
    parent_cur = (cur_q | bit_l) & ~bit_l1;
    sib_cur    = cur_q ^ bit_l1;
    left_cur   = cur_q - half;
    right_cur  = cur_q + half;
    nx         = cur_q + bit_l1;
    nx_par     = (nx | bit_l) & ~bit_l1;
    step_up    = nx_par >= CurW'(addr_q);
    span_w     = ((BinW+1)'(1) << addr_layer_q) - (BinW+1)'(1);
    span       = span_w[BinW-1:0];
  end

  always_comb begin
    unique case (cmd_i.rd_sel)
      btrb_pkg::RD_CUR:    rd_addr = cur_q[BinW-1:0];
      btrb_pkg::RD_PARENT: rd_addr = parent_cur[BinW-1:0];
      btrb_pkg::RD_SIB:    rd_addr = sib_cur[BinW-1:0];
      btrb_pkg::RD_LEFT:   rd_addr = left_cur[BinW-1:0];
      btrb_pkg::RD_ROOT:   rd_addr = root;
      btrb_pkg::RD_ADDR:   rd_addr = addr_q;
      default:             rd_addr = cur_q[BinW-1:0];
    endcase
  end

  assign wr_addr = cmd_i.wr_sweep ? sw_q : cur_q[BinW-1:0];
  assign wr_bit  = cmd_i.wr_iv ? iv_q : cmd_i.wr_val;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_any) begin
      any_mem[wr_addr] <= wr_bit;
    end
    if (cmd_i.wr_all) begin
      all_mem[wr_addr] <= wr_bit;
    end
    if (cmd_i.rd_en) begin
      rd_any_q <= any_mem[rd_addr];
      rd_all_q <= all_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q     <= '0;
      sw_end_q <= '1;
    end else if (cmd_i.sw_init) begin
      sw_q     <= addr_q - span;
      sw_end_q <= addr_q + span;
    end else if (cmd_i.sw_inc) begin
      sw_q     <= sw_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q        <= req_type_i;
      addr_q       <= addr_in;
      addr_layer_q <= btrb_pkg::layer_of(addr_in);
      cur_q        <= CurW'(addr_in);
      layer_q      <= btrb_pkg::layer_of(addr_in);
      oor_q        <= oor_in;
      invalid_q    <= oor_in || (req_type_i > btrb_pkg::REQ_COVER);
      found_q      <= 1'b0;
      res_q        <= '0;
    end else begin
      unique case (cmd_i.cur_op)
        btrb_pkg::CUR_HOLD: ;
        btrb_pkg::CUR_UP: begin
          cur_q   <= parent_cur;
          layer_q <= layer_q + 1'b1;
        end
        btrb_pkg::CUR_RIGHT: begin
          if (step_up) begin
            cur_q   <= nx_par;
            layer_q <= layer_q + 1'b1;
          end else begin
            cur_q   <= nx;
          end
        end
        btrb_pkg::CUR_DESC: begin
          cur_q   <= cmd_i.desc_left ? left_cur : right_cur;
          layer_q <= layer_q - 1'b1;
        end
        btrb_pkg::CUR_RESTORE: begin
          cur_q   <= CurW'(addr_q);
          layer_q <= addr_layer_q;
        end
        default: ;
      endcase
      if (cmd_i.set_found) begin
        found_q <= 1'b1;
        res_q   <= cur_q[BinW-1:0];
      end
    end
    if (cmd_i.iv_init) begin
      iv_q <= 1'b1;
    end else if (cmd_i.iv_and) begin
      iv_q <= iv_q & rd_all_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (cmd_i.out_zero) begin
        bin_empty_o    <= 1'b0;
        bin_filled_o   <= 1'b0;
        found_o        <= 1'b0;
        result_bin_o   <= '0;
        out_of_range_o <= oor_q;
      end else begin
        bin_empty_o    <= ~rd_any_q;
        bin_filled_o   <= rd_all_q;
        found_o        <= found_q;
        result_bin_o   <= found_q ? res_q : '0;
        out_of_range_o <= 1'b0;
      end
    end
  end

  always_comb begin
    status_o.req         = req_q;
    status_o.invalid     = invalid_q;
    status_o.is_root     = addr_q == root;
    status_o.rd_any      = rd_any_q;
    status_o.rd_all      = rd_all_q;
    status_o.iv          = iv_q;
    status_o.cur_is_root = cur_q == CurW'(root);
    status_o.layer_lt_rl = layer_q < rl;
    status_o.layer_zero  = layer_q == '0;
    status_o.nx_over_top = nx > CurW'(top);
    status_o.sw_last     = sw_q == sw_end_q;
  end

endmodule

// ----- hdl/btrb_ctrl.sv -----
// Controller: sequences tree walks, subtree sweeps and the clearing pass.
module btrb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  btrb_pkg::status_t status_i,
  output btrb_pkg::cmd_t    cmd_o
);

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_DISP  = 5'd2;
  localparam logic [4:0] S_SA    = 5'd3;
  localparam logic [4:0] S_BREAD = 5'd4;
  localparam logic [4:0] S_SB0   = 5'd5;
  localparam logic [4:0] S_SBP   = 5'd6;
  localparam logic [4:0] S_SBC   = 5'd7;
  localparam logic [4:0] S_RA    = 5'd8;
  localparam logic [4:0] S_RAS   = 5'd9;
  localparam logic [4:0] S_RB    = 5'd10;
  localparam logic [4:0] S_SUB   = 5'd11;
  localparam logic [4:0] S_FE0   = 5'd12;
  localparam logic [4:0] S_FEL   = 5'd13;
  localparam logic [4:0] S_FER   = 5'd14;
  localparam logic [4:0] S_DCK   = 5'd15;
  localparam logic [4:0] S_DCH   = 5'd16;
  localparam logic [4:0] S_DRD   = 5'd17;
  localparam logic [4:0] S_FF0   = 5'd18;
  localparam logic [4:0] S_FFS   = 5'd19;
  localparam logic [4:0] S_FFC   = 5'd20;
  localparam logic [4:0] S_CV0   = 5'd21;
  localparam logic [4:0] S_CVL   = 5'd22;
  localparam logic [4:0] S_CVP   = 5'd23;
  localparam logic [4:0] S_FRD   = 5'd24;
  localparam logic [4:0] S_FIN   = 5'd25;
  localparam logic [4:0] S_ZERO  = 5'd26;

  logic [4:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = ~out_valid_q | out_ready_i;
  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLR: begin
        cmd_o.wr_sweep = 1'b1;
        cmd_o.wr_any   = 1'b1;
        cmd_o.wr_all   = 1'b1;
        cmd_o.sw_inc   = 1'b1;
        if (status_i.sw_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        if (status_i.invalid) begin
          state_d = S_ZERO;
        end else begin
          unique case (status_i.req)
            btrb_pkg::REQ_SET, btrb_pkg::REQ_RESET: begin
              if (status_i.is_root) begin
                cmd_o.sw_init = 1'b1;
                state_d       = S_SUB;
              end else begin
                cmd_o.rd_en  = 1'b1;
                cmd_o.rd_sel = btrb_pkg::RD_CUR;
                state_d      = (status_i.req == btrb_pkg::REQ_SET) ? S_SA : S_RA;
              end
            end
            btrb_pkg::REQ_QUERY: state_d = S_FRD;
            btrb_pkg::REQ_FIND_EMPTY: begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = btrb_pkg::RD_ROOT;
              state_d      = S_FE0;
            end
            btrb_pkg::REQ_FIND_FILLED: begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = btrb_pkg::RD_CUR;
              state_d      = S_FF0;
            end
            btrb_pkg::REQ_COVER: begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = btrb_pkg::RD_CUR;
              state_d      = S_CV0;
            end
            default: state_d = S_ZERO;
          endcase
        end
      end
      // any-map climb on set: mark upward until an already marked node or the root layer
      S_SA: begin
        cmd_o.wr_any = 1'b1;
        cmd_o.wr_val = 1'b1;
        if (!status_i.rd_any && status_i.layer_lt_rl) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = btrb_pkg::RD_PARENT;
          cmd_o.cur_op = btrb_pkg::CUR_UP;
        end else begin
          cmd_o.cur_op = btrb_pkg::CUR_RESTORE;
          state_d      = S_BREAD;
        end
      end
      S_BREAD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = btrb_pkg::RD_CUR;
        state_d      = (status_i.req == btrb_pkg::REQ_SET) ? S_SB0 : S_RB;
      end
      S_SB0: begin
        cmd_o.wr_all  = 1'b1;
        cmd_o.wr_val  = 1'b1;
        cmd_o.iv_init = 1'b1;
        if (!status_i.rd_all && status_i.layer_lt_rl) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = btrb_pkg::RD_SIB;
          state_d      = S_SBP;
        end else begin
          cmd_o.sw_init = 1'b1;
          state_d       = S_SUB;
        end
      end
      S_SBP: begin
        cmd_o.iv_and = 1'b1;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = btrb_pkg::RD_PARENT;
        cmd_o.cur_op = btrb_pkg::CUR_UP;
        state_d      = S_SBC;
      end
      S_SBC: begin
        cmd_o.wr_all = 1'b1;
        cmd_o.wr_iv  = 1'b1;
        // stop once the parent already held the new value
        if (status_i.rd_all != status_i.iv && status_i.layer_lt_rl) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = btrb_pkg::RD_SIB;
          state_d      = S_SBP;
        end else begin
          cmd_o.sw_init = 1'b1;
          state_d       = S_SUB;
        end
      end
      S_RA: begin
        cmd_o.wr_any = 1'b1;
        if (status_i.rd_any && status_i.layer_lt_rl) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = btrb_pkg::RD_SIB;
          state_d      = S_RAS;
        end else begin
          cmd_o.cur_op = btrb_pkg::CUR_RESTORE;
          state_d      = S_BREAD;
        end
      end
      S_RAS: begin
        if (status_i.rd_any) begin
          cmd_o.cur_op = btrb_pkg::CUR_RESTORE;
          state_d      = S_BREAD;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = btrb_pkg::RD_PARENT;
          cmd_o.cur_op = btrb_pkg::CUR_UP;
          state_d      = S_RA;
        end
      end
      S_RB: begin
        cmd_o.wr_all = 1'b1;
        if (status_i.rd_all && status_i.layer_lt_rl) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = btrb_pkg::RD_PARENT;
          cmd_o.cur_op = btrb_pkg::CUR_UP;
        end else begin
          cmd_o.sw_init = 1'b1;
          state_d       = S_SUB;
        end
      end
      S_SUB: begin
        cmd_o.wr_sweep = 1'b1;
        cmd_o.wr_any   = 1'b1;
        cmd_o.wr_all   = 1'b1;
        cmd_o.wr_val   = status_i.req == btrb_pkg::REQ_SET;
        cmd_o.sw_inc   = 1'b1;
        if (status_i.sw_last) state_d = S_FRD;
      end
      S_FE0: begin
        if (status_i.rd_all) begin
          state_d = S_FRD;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = btrb_pkg::RD_CUR;
          state_d      = S_FEL;
        end
      end
      // scan right and up over wholly filled subtrees
      S_FEL: begin
        if (!status_i.rd_any) begin
          cmd_o.set_found = 1'b1;
          state_d         = S_FRD;
        end else if (!status_i.rd_all) begin
          state_d = S_DCK;
        end else if (status_i.nx_over_top) begin
          state_d = S_FRD;
        end else begin
          cmd_o.cur_op = btrb_pkg::CUR_RIGHT;
          state_d      = S_FER;
        end
      end
      S_FER: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = btrb_pkg::RD_CUR;
        state_d      = status_i.cur_is_root ? S_DCK : S_FEL;
      end
      S_DCK: begin
        if (!status_i.rd_any) begin
          cmd_o.set_found = 1'b1;
          state_d         = S_FRD;
        end else if (status_i.layer_zero) begin
          state_d = S_FRD;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = btrb_pkg::RD_LEFT;
          state_d      = S_DCH;
        end
      end
      S_DCH: begin
        cmd_o.cur_op    = btrb_pkg::CUR_DESC;
        cmd_o.desc_left = ~status_i.rd_all;
        state_d         = S_DRD;
      end
      S_DRD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = btrb_pkg::RD_CUR;
        state_d      = S_DCK;
      end
      S_FF0: begin
        state_d = status_i.rd_any ? S_FFS : S_FRD;
      end
      S_FFS: begin
        if (status_i.layer_zero) begin
          cmd_o.set_found = 1'b1;
          state_d         = S_FRD;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = btrb_pkg::RD_LEFT;
          state_d      = S_FFC;
        end
      end
      S_FFC: begin
        cmd_o.cur_op    = btrb_pkg::CUR_DESC;
        cmd_o.desc_left = status_i.rd_any;
        state_d         = S_FFS;
      end
      S_CV0: begin
        if (!status_i.rd_all) begin
          cmd_o.set_found = 1'b1;
          state_d         = S_FRD;
        end else begin
          state_d = S_CVL;
        end
      end
      S_CVL: begin
        if (status_i.cur_is_root) begin
          cmd_o.set_found = 1'b1;
          state_d         = S_FRD;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = btrb_pkg::RD_PARENT;
          state_d      = S_CVP;
        end
      end
      S_CVP: begin
        if (!status_i.rd_all) begin
          cmd_o.set_found = 1'b1;
          state_d         = S_FRD;
        end else begin
          cmd_o.cur_op = btrb_pkg::CUR_UP;
          state_d      = S_CVL;
        end
      end
      S_FRD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = btrb_pkg::RD_ADDR;
        state_d      = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_ZERO: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_zero = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- hdl/binary_tree_range_bitmap_unit.sv -----
// Top level: range bitmap over an in-order binary tree of bins.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------------------
//  in      | input     | in_valid_i/in_ready_o | req_type_i, bin_number_i, whole_map_i
//  out     | output    | out_valid_o/out_ready_i | bin_empty_o, bin_filled_o, found_o,
//          |           |                       | result_bin_o, out_of_range_o
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_data_i (root layer)
//
// After reset a clearing pass walks both maps before the first request is taken.
// A request walks the tree one layer at a time through the single read port of the map
// memory; set and reset add a subtree sweep of 2^(l+1)-1 bins for a bin in layer l,
// up to 2^(root+1)-1 bins for the whole map.
// The next request is taken while a result waits; a stalled output holds the controller
// in its final state. Config writes are always taken.
module binary_tree_range_bitmap_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [btrb_pkg::ReqW-1:0]   req_type_i,
  input  logic [btrb_pkg::BinW-1:0]   bin_number_i,
  input  logic                        whole_map_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        bin_empty_o,
  output logic                        bin_filled_o,
  output logic                        found_o,
  output logic [btrb_pkg::BinW-1:0]   result_bin_o,
  output logic                        out_of_range_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [btrb_pkg::LayerW-1:0] cfg_data_i
);

  btrb_pkg::cmd_t    cmd;
  btrb_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  btrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  btrb_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .req_type_i     (req_type_i),
    .bin_number_i   (bin_number_i),
    .whole_map_i    (whole_map_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .bin_empty_o    (bin_empty_o),
    .bin_filled_o   (bin_filled_o),
    .found_o        (found_o),
    .result_bin_o   (result_bin_o),
    .out_of_range_o (out_of_range_o)
  );

endmodule
